@@ hw/rtl/bfe_pkg.sv @@
// Blob field evaluator: shared constants, payload structs, command codes.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bfe_pkg;

    localparam int MAX_ATOMS = 64;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ATOMS + 1);
    localparam int STEP_W    = $clog2(FRAC_BITS);
    localparam int COORD_W   = 32;
    localparam int RAD_W     = 31;
    localparam int R2_W      = 2 * RAD_W;
    localparam int WGT_W     = 32;
    localparam int DIFF_W    = COORD_W + 2;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int FIELD_W   = 48;
    localparam int SUM_W     = FIELD_W + 1;
    localparam int HELD_W    = 7;
    localparam int POLY_W    = FRAC_BITS + 5;
    localparam int RECIP_SH  = FRAC_BITS + 9;

    localparam logic [POLY_W-1:0] ONE = POLY_W'(1) << FRAC_BITS;
    localparam logic [POLY_W-1:0] C17 = POLY_W'(17) << FRAC_BITS;
    localparam logic [POLY_W-1:0] C22 = POLY_W'(22) << FRAC_BITS;
    localparam logic [DIFF_W-1:0] RECIP9 =
        DIFF_W'(((64'd1 << RECIP_SH) + 64'd8) / 64'd9);

    localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

    localparam logic [1:0] OP_LOAD_SPHERE = 2'd0;
    localparam logic [1:0] OP_LOAD_CYL    = 2'd1;
    localparam logic [1:0] OP_EVAL        = 2'd2;
    localparam logic [1:0] OP_CLEAR       = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]                 opcode;
        logic signed [COORD_W-1:0]  a_x;
        logic signed [COORD_W-1:0]  a_y;
        logic signed [COORD_W-1:0]  a_z;
        logic signed [COORD_W-1:0]  b_x;
        logic signed [COORD_W-1:0]  b_y;
        logic signed [COORD_W-1:0]  b_z;
        logic [RAD_W-1:0]           atom_radius;
        logic signed [WGT_W-1:0]    atom_weight;
    } req_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0]  field_value;
        logic [1:0]                 status;
        logic [HELD_W-1:0]          atoms_held;
    } rsp_t;

    typedef struct packed {
        logic                       is_cyl;
        logic signed [COORD_W-1:0]  sx;
        logic signed [COORD_W-1:0]  sy;
        logic signed [COORD_W-1:0]  sz;
        logic signed [COORD_W-1:0]  ex;
        logic signed [COORD_W-1:0]  ey;
        logic signed [COORD_W-1:0]  ez;
        logic [R2_W-1:0]            r2;
        logic signed [WGT_W-1:0]    weight;
    } atom_t;

    typedef enum logic [5:0] {
        DP_NOP, DP_CAPTURE, DP_RSQ, DP_WRITE, DP_READ, DP_SETUP,
        DP_C0, DP_C1, DP_C2, DP_C3, DP_C4, DP_C5, DP_C6,
        DP_CLAMP, DP_DIV, DP_T0, DP_T1, DP_T2, DP_T3,
        DP_DIFF, DP_S0, DP_S1, DP_S2, DP_S3, DP_QSET,
        DP_PA, DP_PB, DP_PC, DP_PD, DP_PE, DP_PF, DP_PG, DP_PH, DP_PI,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t             op;
        logic [IDX_W-1:0]   addr;
        logic [1:0]         status;
        logic [CNT_W-1:0]   count;
    } dp_cmd_t;

    typedef struct packed {
        logic is_cyl;
        logic seg_inner;
        logic in_range;
    } dp_stat_t;

    typedef enum logic [5:0] {
        S_IDLE, S_LOAD, S_WRITE, S_READ, S_SETUP,
        S_C0, S_C1, S_C2, S_C3, S_C4, S_C5, S_C6,
        S_CLAMP, S_TDIV, S_T0, S_T1, S_T2, S_T3,
        S_DIFF, S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_QCHK, S_QDIV,
        S_PA, S_PB, S_PC, S_PD, S_PE, S_PF, S_PG, S_PH, S_PI,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/bfe_ifs.sv @@
// Blob field evaluator: request and response channel interfaces.
// Depends on bfe_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bfe_req_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         opcode;
    logic signed [bfe_pkg::COORD_W-1:0] a_x;
    logic signed [bfe_pkg::COORD_W-1:0] a_y;
    logic signed [bfe_pkg::COORD_W-1:0] a_z;
    logic signed [bfe_pkg::COORD_W-1:0] b_x;
    logic signed [bfe_pkg::COORD_W-1:0] b_y;
    logic signed [bfe_pkg::COORD_W-1:0] b_z;
    logic [bfe_pkg::RAD_W-1:0]          atom_radius;
    logic signed [bfe_pkg::WGT_W-1:0]   atom_weight;

    modport source (output valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z,
                    atom_radius, atom_weight, input ready);
    modport sink   (input valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z,
                    atom_radius, atom_weight, output ready);
endinterface

interface bfe_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [bfe_pkg::FIELD_W-1:0] field_value;
    logic [1:0]                         status;
    logic [bfe_pkg::HELD_W-1:0]         atoms_held;

    modport source (output valid, field_value, status, atoms_held, input ready);
    modport sink   (input valid, field_value, status, atoms_held, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bfe_datapath.sv @@
// Blob field evaluator datapath: atom table, shared multiplier, bit-serial
// divider, distance and polynomial registers, field accumulator. Uses bfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfe_datapath (
    input  wire logic               clk,
    input  wire bfe_pkg::req_t      req_data,
    input  wire bfe_pkg::dp_cmd_t   cmd,
    output bfe_pkg::dp_stat_t       st,
    output bfe_pkg::rsp_t           rsp_data
);

    localparam int F  = bfe_pkg::FRAC_BITS;
    localparam int DW = bfe_pkg::DIFF_W;
    localparam int PW = bfe_pkg::PROD_W;
    localparam int YW = bfe_pkg::POLY_W;

    bfe_pkg::atom_t mem [bfe_pkg::MAX_ATOMS];
    bfe_pkg::atom_t ent_reg;
    bfe_pkg::atom_t new_atom;
    bfe_pkg::req_t  cap_reg;
    bfe_pkg::rsp_t  out_reg;

    logic signed [DW-1:0] dir_reg  [3];
    logic signed [DW-1:0] w_reg    [3];
    logic signed [DW-1:0] near_reg [3];
    logic signed [DW-1:0] d_reg    [3];
    logic signed [DW-1:0] pt       [3];
    logic signed [DW-1:0] start    [3];
    logic signed [DW-1:0] endp     [3];

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] acc_reg;
    logic [PW-1:0]        len2_reg;
    logic [PW-1:0]        rem_reg;
    logic [PW-1:0]        den_reg;
    logic [F-1:0]         quo_reg;
    logic [YW-1:0]        poly_reg;
    logic signed [bfe_pkg::FIELD_W-1:0] sum_reg;

    logic signed [DW-1:0] mul_a;
    logic signed [DW-1:0] mul_b;
    logic [PW-1:0]        rem_sh;
    logic                 div_ge;
    logic                 dot_le0;
    logic                 dot_ge;
    logic [YW-1:0]        c_val;
    logic signed [bfe_pkg::SUM_W-1:0]   sum_ext;
    logic signed [bfe_pkg::FIELD_W-1:0] sum_sat;
    logic                 cyl;

    assign pt[0]    = DW'(cap_reg.a_x);
    assign pt[1]    = DW'(cap_reg.a_y);
    assign pt[2]    = DW'(cap_reg.a_z);
    assign start[0] = DW'(ent_reg.sx);
    assign start[1] = DW'(ent_reg.sy);
    assign start[2] = DW'(ent_reg.sz);
    assign endp[0]  = DW'(ent_reg.ex);
    assign endp[1]  = DW'(ent_reg.ey);
    assign endp[2]  = DW'(ent_reg.ez);

    assign cyl = (cap_reg.opcode == bfe_pkg::OP_LOAD_CYL) &&
                 ((cap_reg.a_x != cap_reg.b_x) || (cap_reg.a_y != cap_reg.b_y) ||
                  (cap_reg.a_z != cap_reg.b_z));

    always_comb
    begin
        new_atom.is_cyl = cyl;
        new_atom.sx     = cap_reg.a_x;
        new_atom.sy     = cap_reg.a_y;
        new_atom.sz     = cap_reg.a_z;
        new_atom.ex     = cyl ? cap_reg.b_x : cap_reg.a_x;
        new_atom.ey     = cyl ? cap_reg.b_y : cap_reg.a_y;
        new_atom.ez     = cyl ? cap_reg.b_z : cap_reg.a_z;
        new_atom.r2     = prod_reg[bfe_pkg::R2_W-1:0];
        new_atom.weight = cap_reg.atom_weight;
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            bfe_pkg::DP_RSQ:
            begin
                mul_a = DW'(cap_reg.atom_radius);
                mul_b = DW'(cap_reg.atom_radius);
            end
            bfe_pkg::DP_C0: begin mul_a = w_reg[0];   mul_b = dir_reg[0]; end
            bfe_pkg::DP_C1: begin mul_a = dir_reg[0]; mul_b = dir_reg[0]; end
            bfe_pkg::DP_C2: begin mul_a = w_reg[1];   mul_b = dir_reg[1]; end
            bfe_pkg::DP_C3: begin mul_a = dir_reg[1]; mul_b = dir_reg[1]; end
            bfe_pkg::DP_C4: begin mul_a = w_reg[2];   mul_b = dir_reg[2]; end
            bfe_pkg::DP_C5: begin mul_a = dir_reg[2]; mul_b = dir_reg[2]; end
            bfe_pkg::DP_T0: begin mul_a = DW'(quo_reg); mul_b = dir_reg[0]; end
            bfe_pkg::DP_T1: begin mul_a = DW'(quo_reg); mul_b = dir_reg[1]; end
            bfe_pkg::DP_T2: begin mul_a = DW'(quo_reg); mul_b = dir_reg[2]; end
            bfe_pkg::DP_S0: begin mul_a = d_reg[0]; mul_b = d_reg[0]; end
            bfe_pkg::DP_S1: begin mul_a = d_reg[1]; mul_b = d_reg[1]; end
            bfe_pkg::DP_S2: begin mul_a = d_reg[2]; mul_b = d_reg[2]; end
            bfe_pkg::DP_PB, bfe_pkg::DP_PD:
            begin
                mul_a = DW'(poly_reg);
                mul_b = DW'(quo_reg);
            end
            bfe_pkg::DP_PF: begin mul_a = DW'(poly_reg); mul_b = bfe_pkg::RECIP9; end
            bfe_pkg::DP_PH: begin mul_a = DW'(ent_reg.weight); mul_b = DW'(poly_reg); end
            default: ;
        endcase
    end

    assign rem_sh  = {rem_reg[PW-2:0], 1'b0};
    assign div_ge  = (rem_sh >= den_reg);
    assign dot_le0 = acc_reg[PW-1] || (acc_reg == '0);
    assign dot_ge  = !acc_reg[PW-1] && ($unsigned(acc_reg) >= len2_reg);
    assign c_val   = YW'(prod_reg >> bfe_pkg::RECIP_SH);

    always_comb
    begin
        sum_ext = bfe_pkg::SUM_W'(sum_reg) + bfe_pkg::SUM_W'(prod_reg >>> F);
        if (sum_ext[bfe_pkg::SUM_W-1] != sum_ext[bfe_pkg::FIELD_W-1])
        begin
            sum_sat = sum_ext[bfe_pkg::SUM_W-1] ? bfe_pkg::FIELD_MIN : bfe_pkg::FIELD_MAX;
        end
        else
        begin
            sum_sat = sum_ext[bfe_pkg::FIELD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == bfe_pkg::DP_WRITE)
        begin
            mem[cmd.addr] <= new_atom;
        end
        if (cmd.op == bfe_pkg::DP_READ)
        begin
            ent_reg <= mem[cmd.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (cmd.op)
            bfe_pkg::DP_CAPTURE:
            begin
                cap_reg <= req_data;
                sum_reg <= '0;
            end
            bfe_pkg::DP_SETUP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dir_reg[i]  <= endp[i] - start[i];
                    w_reg[i]    <= pt[i] - start[i];
                    near_reg[i] <= start[i];
                end
                acc_reg  <= '0;
                len2_reg <= '0;
            end
            bfe_pkg::DP_C1, bfe_pkg::DP_C3, bfe_pkg::DP_C5,
            bfe_pkg::DP_S1, bfe_pkg::DP_S2, bfe_pkg::DP_S3:
            begin
                acc_reg <= acc_reg + prod_reg;
            end
            bfe_pkg::DP_C2, bfe_pkg::DP_C4, bfe_pkg::DP_C6:
            begin
                len2_reg <= len2_reg + $unsigned(prod_reg);
            end
            bfe_pkg::DP_CLAMP:
            begin
                if (dot_le0)
                begin
                    for (int i = 0; i < 3; i++) near_reg[i] <= start[i];
                end
                else if (dot_ge)
                begin
                    for (int i = 0; i < 3; i++) near_reg[i] <= endp[i];
                end
                else
                begin
                    rem_reg <= $unsigned(acc_reg);
                    den_reg <= len2_reg;
                    quo_reg <= '0;
                end
            end
            bfe_pkg::DP_DIV:
            begin
                rem_reg <= div_ge ? (rem_sh - den_reg) : rem_sh;
                quo_reg <= {quo_reg[F-2:0], div_ge};
            end
            bfe_pkg::DP_T1: near_reg[0] <= start[0] + DW'(prod_reg >>> F);
            bfe_pkg::DP_T2: near_reg[1] <= start[1] + DW'(prod_reg >>> F);
            bfe_pkg::DP_T3: near_reg[2] <= start[2] + DW'(prod_reg >>> F);
            bfe_pkg::DP_DIFF:
            begin
                for (int i = 0; i < 3; i++) d_reg[i] <= pt[i] - near_reg[i];
                acc_reg <= '0;
            end
            bfe_pkg::DP_QSET:
            begin
                rem_reg <= $unsigned(acc_reg);
                den_reg <= PW'(ent_reg.r2);
                quo_reg <= '0;
            end
            bfe_pkg::DP_PA: poly_reg <= bfe_pkg::C17 - (YW'(quo_reg) << 2);
            bfe_pkg::DP_PC: poly_reg <= bfe_pkg::C22 - YW'(prod_reg >> F);
            bfe_pkg::DP_PE: poly_reg <= YW'(prod_reg >> F);
            bfe_pkg::DP_PG: poly_reg <= (c_val >= bfe_pkg::ONE) ? '0 : bfe_pkg::ONE - c_val;
            bfe_pkg::DP_PI: sum_reg <= sum_sat;
            bfe_pkg::DP_OUT:
            begin
                out_reg.field_value <= sum_reg;
                out_reg.status      <= cmd.status;
                out_reg.atoms_held  <= bfe_pkg::HELD_W'(cmd.count);
            end
            default: ;
        endcase
    end

    assign st.is_cyl    = ent_reg.is_cyl;
    assign st.seg_inner = !dot_le0 && !dot_ge;
    assign st.in_range  = ($unsigned(acc_reg) < PW'(ent_reg.r2));
    assign rsp_data     = out_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bfe_ctrl.sv @@
// Blob field evaluator controller: opcode sequencing, atom count and index,
// divider step count, response valid. Uses bfe_pkg command and status types.
`timescale 1ns / 1ps
`default_nettype none

module bfe_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    input  wire logic [1:0]         req_opcode,
    output logic                    req_ready,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    input  wire bfe_pkg::dp_stat_t  st,
    output bfe_pkg::dp_cmd_t        cmd
);

    localparam int CW = bfe_pkg::CNT_W;
    localparam int IW = bfe_pkg::IDX_W;
    localparam int SW = bfe_pkg::STEP_W;

    bfe_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [SW-1:0]   step_reg, step_next;
    logic [1:0]      status_reg, status_next;
    logic            rsp_valid_reg, rsp_valid_next;
    logic            last_atom;
    logic            step_last;

    assign last_atom = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign step_last = (step_reg == SW'(bfe_pkg::FRAC_BITS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfe_pkg::S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            step_reg      <= '0;
            status_reg    <= bfe_pkg::STAT_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_ready      = 1'b0;
        cmd.op         = bfe_pkg::DP_NOP;
        cmd.addr       = idx_reg;
        cmd.status     = status_reg;
        cmd.count      = count_reg;
        unique case (state_reg)
            bfe_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op      = bfe_pkg::DP_CAPTURE;
                    status_next = bfe_pkg::STAT_OK;
                    unique case (req_opcode) inside
                        bfe_pkg::OP_LOAD_SPHERE, bfe_pkg::OP_LOAD_CYL:
                        begin
                            state_next = bfe_pkg::S_LOAD;
                        end
                        bfe_pkg::OP_EVAL:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = bfe_pkg::STAT_EMPTY;
                                state_next  = bfe_pkg::S_DONE;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = bfe_pkg::S_READ;
                            end
                        end
                        bfe_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            state_next = bfe_pkg::S_DONE;
                        end
                    endcase
                end
            end
            bfe_pkg::S_LOAD:
            begin
                if (count_reg >= CW'(bfe_pkg::MAX_ATOMS))
                begin
                    status_next = bfe_pkg::STAT_FULL;
                    state_next  = bfe_pkg::S_DONE;
                end
                else
                begin
                    cmd.op     = bfe_pkg::DP_RSQ;
                    state_next = bfe_pkg::S_WRITE;
                end
            end
            bfe_pkg::S_WRITE:
            begin
                cmd.op     = bfe_pkg::DP_WRITE;
                cmd.addr   = count_reg[IW-1:0];
                count_next = count_reg + CW'(1);
                state_next = bfe_pkg::S_DONE;
            end
            bfe_pkg::S_READ:
            begin
                cmd.op     = bfe_pkg::DP_READ;
                state_next = bfe_pkg::S_SETUP;
            end
            bfe_pkg::S_SETUP:
            begin
                cmd.op     = bfe_pkg::DP_SETUP;
                state_next = st.is_cyl ? bfe_pkg::S_C0 : bfe_pkg::S_DIFF;
            end
            bfe_pkg::S_C0: begin cmd.op = bfe_pkg::DP_C0; state_next = bfe_pkg::S_C1; end
            bfe_pkg::S_C1: begin cmd.op = bfe_pkg::DP_C1; state_next = bfe_pkg::S_C2; end
            bfe_pkg::S_C2: begin cmd.op = bfe_pkg::DP_C2; state_next = bfe_pkg::S_C3; end
            bfe_pkg::S_C3: begin cmd.op = bfe_pkg::DP_C3; state_next = bfe_pkg::S_C4; end
            bfe_pkg::S_C4: begin cmd.op = bfe_pkg::DP_C4; state_next = bfe_pkg::S_C5; end
            bfe_pkg::S_C5: begin cmd.op = bfe_pkg::DP_C5; state_next = bfe_pkg::S_C6; end
            bfe_pkg::S_C6: begin cmd.op = bfe_pkg::DP_C6; state_next = bfe_pkg::S_CLAMP; end
            bfe_pkg::S_CLAMP:
            begin
                cmd.op = bfe_pkg::DP_CLAMP;
                if (st.seg_inner)
                begin
                    step_next  = '0;
                    state_next = bfe_pkg::S_TDIV;
                end
                else
                begin
                    state_next = bfe_pkg::S_DIFF;
                end
            end
            bfe_pkg::S_TDIV:
            begin
                cmd.op    = bfe_pkg::DP_DIV;
                step_next = step_reg + SW'(1);
                if (step_last)
                begin
                    state_next = bfe_pkg::S_T0;
                end
            end
            bfe_pkg::S_T0: begin cmd.op = bfe_pkg::DP_T0; state_next = bfe_pkg::S_T1; end
            bfe_pkg::S_T1: begin cmd.op = bfe_pkg::DP_T1; state_next = bfe_pkg::S_T2; end
            bfe_pkg::S_T2: begin cmd.op = bfe_pkg::DP_T2; state_next = bfe_pkg::S_T3; end
            bfe_pkg::S_T3: begin cmd.op = bfe_pkg::DP_T3; state_next = bfe_pkg::S_DIFF; end
            bfe_pkg::S_DIFF: begin cmd.op = bfe_pkg::DP_DIFF; state_next = bfe_pkg::S_SQ0; end
            bfe_pkg::S_SQ0: begin cmd.op = bfe_pkg::DP_S0; state_next = bfe_pkg::S_SQ1; end
            bfe_pkg::S_SQ1: begin cmd.op = bfe_pkg::DP_S1; state_next = bfe_pkg::S_SQ2; end
            bfe_pkg::S_SQ2: begin cmd.op = bfe_pkg::DP_S2; state_next = bfe_pkg::S_SQ3; end
            bfe_pkg::S_SQ3: begin cmd.op = bfe_pkg::DP_S3; state_next = bfe_pkg::S_QCHK; end
            bfe_pkg::S_QCHK:
            begin
                cmd.op = bfe_pkg::DP_QSET;
                if (st.in_range)
                begin
                    step_next  = '0;
                    state_next = bfe_pkg::S_QDIV;
                end
                else if (last_atom)
                begin
                    state_next = bfe_pkg::S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = bfe_pkg::S_READ;
                end
            end
            bfe_pkg::S_QDIV:
            begin
                cmd.op    = bfe_pkg::DP_DIV;
                step_next = step_reg + SW'(1);
                if (step_last)
                begin
                    state_next = bfe_pkg::S_PA;
                end
            end
            bfe_pkg::S_PA: begin cmd.op = bfe_pkg::DP_PA; state_next = bfe_pkg::S_PB; end
            bfe_pkg::S_PB: begin cmd.op = bfe_pkg::DP_PB; state_next = bfe_pkg::S_PC; end
            bfe_pkg::S_PC: begin cmd.op = bfe_pkg::DP_PC; state_next = bfe_pkg::S_PD; end
            bfe_pkg::S_PD: begin cmd.op = bfe_pkg::DP_PD; state_next = bfe_pkg::S_PE; end
            bfe_pkg::S_PE: begin cmd.op = bfe_pkg::DP_PE; state_next = bfe_pkg::S_PF; end
            bfe_pkg::S_PF: begin cmd.op = bfe_pkg::DP_PF; state_next = bfe_pkg::S_PG; end
            bfe_pkg::S_PG: begin cmd.op = bfe_pkg::DP_PG; state_next = bfe_pkg::S_PH; end
            bfe_pkg::S_PH: begin cmd.op = bfe_pkg::DP_PH; state_next = bfe_pkg::S_PI; end
            bfe_pkg::S_PI:
            begin
                cmd.op = bfe_pkg::DP_PI;
                if (last_atom)
                begin
                    state_next = bfe_pkg::S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = bfe_pkg::S_READ;
                end
            end
            bfe_pkg::S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.op         = bfe_pkg::DP_OUT;
                    rsp_valid_next = 1'b1;
                    state_next     = bfe_pkg::S_IDLE;
                end
            end
            default: state_next = bfe_pkg::S_IDLE;
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(bfe_pkg::MAX_ATOMS))
        else $error("atom count above table depth");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfe_pkg::S_IDLE && req_valid) |=> (state_reg != bfe_pkg::S_IDLE))
        else $error("accepted beat did not start work");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == bfe_pkg::DP_WRITE) |-> (count_reg < CW'(bfe_pkg::MAX_ATOMS)))
        else $error("table write past full");

    a_done_posts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfe_pkg::S_DONE && (!rsp_valid_reg || rsp_ready)) |=> rsp_valid_reg)
        else $error("finished beat not posted");

endmodule

`default_nettype wire

@@ hw/rtl/blob_field_evaluator_core.sv @@
// Blob field evaluator top level: joins controller and datapath to the
// request and response channels. Depends on bfe_pkg, bfe_ifs, bfe_ctrl, bfe_datapath.
//
//   channel  dir  beat contents
//   req      in   opcode, a_x/y/z, b_x/y/z, atom_radius, atom_weight
//   rsp      out  field_value, status, atoms_held
//
// Evaluate walks every held atom; an atom in range (hit) also runs the divider and
// polynomial steps, and a cylinder adds projection steps (clamped or inner).
// Built around the shared 34x34 multiplier and the one-bit-per-cycle divider.
// Reset empties the table; no clearing pass. A stalled rsp holds the result
// register while the next req beat is still taken.
`timescale 1ns / 1ps
`default_nettype none

module blob_field_evaluator_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bfe_req_if.sink     req,
    bfe_rsp_if.source   rsp
);

    bfe_pkg::req_t     req_data;
    bfe_pkg::rsp_t     rsp_data;
    bfe_pkg::dp_cmd_t  cmd;
    bfe_pkg::dp_stat_t st;
    logic              req_ready;
    logic              rsp_valid;

    always_comb
    begin
        req_data.opcode      = req.opcode;
        req_data.a_x         = req.a_x;
        req_data.a_y         = req.a_y;
        req_data.a_z         = req.a_z;
        req_data.b_x         = req.b_x;
        req_data.b_y         = req.b_y;
        req_data.b_z         = req.b_z;
        req_data.atom_radius = req.atom_radius;
        req_data.atom_weight = req.atom_weight;
    end

    bfe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_opcode (req.opcode),
        .req_ready  (req_ready),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp.ready),
        .st         (st),
        .cmd        (cmd)
    );

    bfe_datapath u_datapath (
        .clk      (clk),
        .req_data (req_data),
        .cmd      (cmd),
        .st       (st),
        .rsp_data (rsp_data)
    );

    assign req.ready       = req_ready;
    assign rsp.valid       = rsp_valid;
    assign rsp.field_value = rsp_data.field_value;
    assign rsp.status      = rsp_data.status;
    assign rsp.atoms_held  = rsp_data.atoms_held;

endmodule

`default_nettype wire

@@ tb/bfe_checker.sv @@
// Blob field evaluator checker: watches req and rsp beats, predicts each response
// from its own copy of the atom table, compares field by field. Depends on bfe_pkg.
`timescale 1ns / 1ps

module bfe_checker (
    input  logic          clk,
    input  logic          rst_n,
    bfe_req_if            req,
    bfe_rsp_if            rsp,
    output int            fail_count,
    output int            pending
);

    bit                   cyl_tab [bfe_pkg::MAX_ATOMS];
    logic signed [63:0]   st_tab [bfe_pkg::MAX_ATOMS][3];
    logic signed [63:0]   en_tab [bfe_pkg::MAX_ATOMS][3];
    logic [63:0]          r2_tab [bfe_pkg::MAX_ATOMS];
    logic signed [63:0]   wgt_tab [bfe_pkg::MAX_ATOMS];
    int                   held;
    bfe_pkg::rsp_t        field_queue [$];

    function automatic logic [63:0] sq_dist(logic signed [63:0] p [3],
                                            logic signed [63:0] c [3]);
        logic [64:0]        s;
        logic signed [63:0] d;
        logic [63:0]        m;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            d = p[i] - c[i];
            m = d < 0 ? -d : d;
            s = s + m * m;
            if (s[64])
                s = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] seg_dist(logic signed [63:0] p [3],
                                             logic signed [63:0] s [3],
                                             logic signed [63:0] e [3]);
        logic signed [127:0] dot, len2, num;
        logic signed [63:0]  dir [3];
        logic signed [63:0]  nr [3];
        logic signed [63:0]  t, pr;
        dot = 0;
        len2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            dir[i] = e[i] - s[i];
            dot = dot + 128'(p[i] - s[i]) * 128'(dir[i]);
            len2 = len2 + 128'(dir[i]) * 128'(dir[i]);
        end
        if (dot <= 0)
            return sq_dist(p, s);
        if (dot >= len2)
            return sq_dist(p, e);
        num = dot <<< bfe_pkg::FRAC_BITS;
        t = 64'(num / len2);
        for (int i = 0; i < 3; i++)
        begin
            pr = t * dir[i];
            nr[i] = s[i] + (pr >>> bfe_pkg::FRAC_BITS);
        end
        return sq_dist(p, nr);
    endfunction

    function automatic logic signed [63:0] atom_contrib(int k, logic signed [63:0] p [3]);
        logic [63:0]        d2, r2, q, a, b, c, f;
        logic [127:0]       num;
        logic signed [63:0] prod;
        r2 = r2_tab[k];
        d2 = cyl_tab[k] ? seg_dist(p, st_tab[k], en_tab[k]) : sq_dist(p, st_tab[k]);
        if (d2 >= r2)
            return 0;
        num = {64'd0, d2} << bfe_pkg::FRAC_BITS;
        q = 64'(num / r2);
        a = 17 * (64'd1 << bfe_pkg::FRAC_BITS) - 4 * q;
        b = 22 * (64'd1 << bfe_pkg::FRAC_BITS) - ((a * q) >> bfe_pkg::FRAC_BITS);
        c = ((b * q) >> bfe_pkg::FRAC_BITS) / 9;
        f = (c >= (64'd1 << bfe_pkg::FRAC_BITS)) ? 0 : (64'd1 << bfe_pkg::FRAC_BITS) - c;
        prod = wgt_tab[k] * $signed(f);
        return prod >>> bfe_pkg::FRAC_BITS;
    endfunction

    function automatic bfe_pkg::rsp_t field_predict(bfe_pkg::req_t r);
        bfe_pkg::rsp_t      o;
        logic signed [63:0] pa [3];
        logic signed [63:0] pb [3];
        logic signed [63:0] sum;
        bit                 cyl;
        pa[0] = r.a_x; pa[1] = r.a_y; pa[2] = r.a_z;
        pb[0] = r.b_x; pb[1] = r.b_y; pb[2] = r.b_z;
        sum = 0;
        o.status = bfe_pkg::STAT_OK;
        if (r.opcode == bfe_pkg::OP_LOAD_SPHERE || r.opcode == bfe_pkg::OP_LOAD_CYL)
        begin
            if (held >= bfe_pkg::MAX_ATOMS)
                o.status = bfe_pkg::STAT_FULL;
            else
            begin
                cyl = r.opcode == bfe_pkg::OP_LOAD_CYL && (pa[0] != pb[0] || pa[1] != pb[1]
                                                           || pa[2] != pb[2]);
                cyl_tab[held] = cyl;
                st_tab[held] = pa;
                en_tab[held] = cyl ? pb : pa;
                r2_tab[held] = 64'(r.atom_radius) * 64'(r.atom_radius);
                wgt_tab[held] = r.atom_weight;
                held++;
            end
        end
        else if (r.opcode == bfe_pkg::OP_EVAL)
        begin
            if (held == 0)
                o.status = bfe_pkg::STAT_EMPTY;
            else
                for (int k = 0; k < held; k++)
                begin
                    sum = sum + atom_contrib(k, pa);
                    if (sum > 64'sd140737488355327)
                        sum = 64'sd140737488355327;
                    if (sum < -64'sd140737488355328)
                        sum = -64'sd140737488355328;
                end
        end
        else
            held = 0;
        o.field_value = sum[bfe_pkg::FIELD_W-1:0];
        o.atoms_held = bfe_pkg::HELD_W'(held);
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        held = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        bfe_pkg::req_t r;
        bfe_pkg::rsp_t e;
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                r = '{req.opcode, req.a_x, req.a_y, req.a_z, req.b_x, req.b_y, req.b_z,
                      req.atom_radius, req.atom_weight};
                field_queue.push_back(field_predict(r));
            end
            if (rsp.valid && rsp.ready)
            begin
                if (field_queue.size() == 0)
                    report_mismatch("unexpected beat", 0, 0);
                else
                begin
                    e = field_queue.pop_front();
                    if (rsp.field_value !== e.field_value)
                        report_mismatch("field_value", 64'(rsp.field_value),
                                        64'(e.field_value));
                    if (rsp.status !== e.status)
                        report_mismatch("status", 64'(rsp.status), 64'(e.status));
                    if (rsp.atoms_held !== e.atoms_held)
                        report_mismatch("atoms_held", 64'(rsp.atoms_held),
                                        64'(e.atoms_held));
                end
            end
            pending = field_queue.size();
        end
    end
endmodule

@@ tb/tb.sv @@
// Blob field evaluator testbench top: clock, reset, request stimulus with random
// gaps, response back-pressure, verdict. Depends on bfe_pkg, bfe_ifs, bfe_checker.
`timescale 1ns / 1ps

module tb;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    bit   stall_long;

    bfe_req_if req ();
    bfe_rsp_if rsp ();

    blob_field_evaluator_core u_top (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));
    bfe_checker u_chk (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
                       .fail_count(fail_count), .pending(pending));

    initial clk = 0;
    always #6 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] coord_rand(bit near);
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return near ? 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16))
                                 : $urandom;
        endcase
    endfunction

    task automatic send_beat(logic [1:0] op, logic [31:0] ax, logic [31:0] ay,
                             logic [31:0] az, logic [31:0] bx, logic [31:0] by,
                             logic [31:0] bz, logic [30:0] rad, logic [31:0] wgt);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            req.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.opcode <= op;
        req.a_x <= ax; req.a_y <= ay; req.a_z <= az;
        req.b_x <= bx; req.b_y <= by; req.b_z <= bz;
        req.atom_radius <= rad;
        req.atom_weight <= wgt;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic random_beat();
        int          r;
        logic [1:0]  op;
        logic [30:0] rad;
        logic [31:0] ax, ay, az;
        r = $urandom_range(0, 99);
        op = r < 35 ? bfe_pkg::OP_LOAD_SPHERE : r < 65 ? bfe_pkg::OP_LOAD_CYL
           : r < 97 ? bfe_pkg::OP_EVAL : bfe_pkg::OP_CLEAR;
        rad = $urandom_range(0, 7) == 0 ? 31'($urandom) : 31'($urandom_range(0, 12 << 16));
        ax = coord_rand(1); ay = coord_rand(1); az = coord_rand(1);
        if ($urandom_range(0, 9) == 0)
            send_beat(op, ax, ay, az, ax, ay, az, rad, $urandom);
        else
            send_beat(op, ax, ay, az, coord_rand(1), coord_rand(1), coord_rand(1), rad,
                      $urandom_range(0, 3) == 0 ? $urandom
                                                : 32'($signed($urandom_range(0, 8 << 16))
                                                      - (4 << 16)));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (stall_long)
            rsp.ready <= $urandom_range(0, 19) == 0;
        else
            rsp.ready <= $urandom_range(0, 2) != 0;
    end

    initial
    begin
        stall_long = 0;
        forever
        begin
            repeat ($urandom_range(200, 2000)) @(posedge clk);
            stall_long = $urandom_range(0, 3) == 0;
        end
    end

    initial
    begin
        #500ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 0;
        req.valid = 0;
        req.opcode = bfe_pkg::OP_EVAL;
        req.a_x = 0; req.a_y = 0; req.a_z = 0;
        req.b_x = 0; req.b_y = 0; req.b_z = 0;
        req.atom_radius = 0;
        req.atom_weight = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_beat(bfe_pkg::OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 0);
        send_beat(bfe_pkg::OP_LOAD_SPHERE, 0, 0, 0, '1, '1, '1, 2 << 16, 1 << 16);
        send_beat(bfe_pkg::OP_LOAD_CYL, 32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0, 1 << 16,
                  32'hFFFF_0000);
        send_beat(bfe_pkg::OP_LOAD_CYL, 0, 32'hFFFE_0000, 0, 0, 32'h0002_0000, 0, 3 << 16,
                  3 << 16);
        send_beat(bfe_pkg::OP_LOAD_SPHERE, 0, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF);
        send_beat(bfe_pkg::OP_LOAD_SPHERE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, '1,
                  32'h8000_0000);
        send_beat(bfe_pkg::OP_LOAD_CYL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, 32'h7FFF_FFFF);
        send_beat(bfe_pkg::OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 0);
        send_beat(bfe_pkg::OP_EVAL, 32'h0000_8000, 32'h0001_0000, 0, '1, '1, '1, '1, '1);
        send_beat(bfe_pkg::OP_EVAL, 0, 32'h0005_0000, 0, 0, 0, 0, 0, 0);
        send_beat(bfe_pkg::OP_EVAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
        send_beat(bfe_pkg::OP_EVAL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0);
        for (int i = 0; i < 60; i++)
            send_beat(bfe_pkg::OP_LOAD_SPHERE, 0, 0, 0, 0, 0, 0, 31'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_beat(bfe_pkg::OP_LOAD_CYL, 0, 0, 0, 1, 1, 1, 1, 1);
        send_beat(bfe_pkg::OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 0);
        send_beat(bfe_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
        send_beat(bfe_pkg::OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 1800; i++)
            random_beat();
        req.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (2500) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
